// File: rtl/core/integral_image_stream_macros.svh
// Assertion macros shared by the checker of the integral image block.
`ifndef INTEGRAL_IMAGE_STREAM_MACROS_SVH
`define INTEGRAL_IMAGE_STREAM_MACROS_SVH

// Checked only while out of reset.
`define IIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define IIS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/iis_pkg.sv
`default_nettype none

package iis_pkg;

  localparam int unsigned MaxWidthDefault = 2048;

  localparam int unsigned ImgWidthW  = 12;
  localparam int unsigned ImgHeightW = 16;
  localparam int unsigned CfgIndexW  = 8;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned SumW       = 32;

  localparam logic [ImgWidthW-1:0]  WidthReset  = 12'd640;
  localparam logic [ImgHeightW-1:0] HeightReset = 16'd480;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] RegImageWidth  = 8'd0;
  localparam logic [CfgIndexW-1:0] RegImageHeight = 8'd1;

  typedef struct packed {
    logic first_row;
    logic row_end;
    logic frame_end;
  } iis_flags_t;

endpackage

`default_nettype wire

// File: rtl/core/iis_line_store.sv
`default_nettype none

module iis_line_store #(
  parameter int unsigned DEPTH = iis_pkg::MaxWidthDefault,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        rd_en_i,
  input  wire logic [ADDR_W-1:0]           rd_addr_i,
  output logic      [iis_pkg::SumW-1:0]    rd_data_o,
  input  wire logic                        wr_en_i,
  input  wire logic [ADDR_W-1:0]           wr_addr_i,
  input  wire logic [iis_pkg::SumW-1:0]    wr_data_i,
  output logic                             busy_o
);
  import iis_pkg::*;

  logic [SumW-1:0]   mem [DEPTH];
  logic [SumW-1:0]   rd_data_q;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              busy_q, busy_d;

  // After reset every entry is swept to zero once, one per cycle.
  always_comb begin
    clr_addr_d = clr_addr_q;
    busy_d     = busy_q;
    if (busy_q) begin
      if (clr_addr_q == ADDR_W'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      busy_q     <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      busy_q     <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

`default_nettype wire

// File: rtl/core/iis_scan.sv
`default_nettype none

module iis_scan #(
  parameter int unsigned MAX_WIDTH = iis_pkg::MaxWidthDefault,
  localparam int unsigned COL_W = $clog2(MAX_WIDTH)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            accept_i,
  input  wire logic [7:0]                      pixel_i,
  input  wire logic [iis_pkg::ImgWidthW-1:0]   width_i,
  input  wire logic [iis_pkg::ImgHeightW-1:0]  height_i,
  output logic      [COL_W-1:0]                col_o,
  output logic      [iis_pkg::SumW-1:0]        prefix_o,
  output iis_pkg::iis_flags_t                  flags_o
);
  import iis_pkg::*;

  localparam int unsigned CMP_W = (COL_W + 1 > ImgWidthW + 1) ? COL_W + 1 : ImgWidthW + 1;
  localparam logic [CMP_W-1:0] MaxW = CMP_W'(MAX_WIDTH);

  logic [COL_W-1:0]      col_q, col_d;
  logic [ImgHeightW-1:0] row_q, row_d;
  logic [SumW-1:0]       prefix_q, prefix_d, prefix_sum;
  logic [CMP_W-1:0]      w_raw, w_eff, col_next;
  logic [ImgHeightW:0]   h_eff, row_next;
  logic                  row_end, frame_end;

  assign w_raw = CMP_W'(width_i);

  // A zero width counts as one; widths beyond the line store saturate.
  always_comb begin
    if (w_raw == '0) begin
      w_eff = CMP_W'(1);
    end else if (w_raw > MaxW) begin
      w_eff = MaxW;
    end else begin
      w_eff = w_raw;
    end
  end

  assign h_eff      = (height_i == '0) ? (ImgHeightW + 1)'(1) : {1'b0, height_i};
  assign col_next   = CMP_W'(col_q) + CMP_W'(1);
  assign row_next   = {1'b0, row_q} + (ImgHeightW + 1)'(1);
  assign row_end    = (col_next >= w_eff);
  assign frame_end  = row_end && (row_next >= h_eff);
  assign prefix_sum = prefix_q + SumW'(pixel_i);

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    prefix_d = prefix_q;
    if (accept_i) begin
      if (row_end) begin
        col_d    = '0;
        prefix_d = '0;
        row_d    = frame_end ? '0 : row_next[ImgHeightW-1:0];
      end else begin
        col_d    = col_next[COL_W-1:0];
        prefix_d = prefix_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      prefix_q <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      prefix_q <= prefix_d;
    end
  end

  assign col_o             = col_q;
  assign prefix_o          = prefix_sum;
  assign flags_o.first_row = (row_q == '0);
  assign flags_o.row_end   = row_end;
  assign flags_o.frame_end = frame_end;

endmodule

`default_nettype wire

// File: rtl/core/integral_image_stream.sv
// Path: a pixel taken is held in the stage-1 register, and its sum then moves into the output register.
// Throughput: one pixel per cycle while the output is not stalled and the line store is not
// being cleared; the line store is read when a pixel is taken and written back as that pixel
// moves into the output register, so one read port and one write port suffice.
// Reset: counters, row sum and handshakes clear at once; the line store is then swept to
// zero, all MAX_WIDTH entries (2048 by default), with pixel_ready_o low.
`default_nettype none

module integral_image_stream #(
  parameter int unsigned MAX_WIDTH = iis_pkg::MaxWidthDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [iis_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  wire logic [iis_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                           pixel_valid_i,
  output logic                                pixel_ready_o,
  input  wire logic [7:0]                     pixel_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [iis_pkg::SumW-1:0]       area_sum_o,
  output logic                                row_end_o,
  output logic                                frame_end_o
);
  import iis_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  logic [ImgWidthW-1:0]  width_q, width_d;
  logic [ImgHeightW-1:0] height_q, height_d;

  logic             accept, busy, s1_adv, fwd;
  logic [COL_W-1:0] scan_col;
  logic [SumW-1:0]  scan_prefix, rd_data, above, sum;
  iis_flags_t       scan_flags;

  logic             s1_valid_q, s1_valid_d;
  logic [COL_W-1:0] s1_col_q;
  logic [SumW-1:0]  s1_prefix_q;
  iis_flags_t       s1_flags_q;
  logic             s1_fwd_q;

  logic             out_valid_q, out_valid_d;
  logic [SumW-1:0]  area_sum_q;
  logic             row_end_q, frame_end_q;

  // Configuration registers.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegImageWidth:  width_d  = cfg_data_i[ImgWidthW-1:0];
        RegImageHeight: height_d = cfg_data_i[ImgHeightW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  assign s1_adv        = !out_valid_q || out_ready_i;
  assign pixel_ready_o = !busy && (!s1_valid_q || s1_adv);
  assign accept        = pixel_valid_i && pixel_ready_o;

  iis_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .pixel_i  (pixel_i),
    .width_i  (width_q),
    .height_i (height_q),
    .col_o    (scan_col),
    .prefix_o (scan_prefix),
    .flags_o  (scan_flags)
  );

  iis_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (scan_col),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_valid_q && s1_adv),
    .wr_addr_i (s1_col_q),
    .wr_data_i (sum),
    .busy_o    (busy)
  );

  // The memory returns old data when a column is read in the cycle it is written
  // (width of one); the sum being written is then taken from the output register.
  assign fwd = s1_valid_q && s1_adv && (s1_col_q == scan_col);

  always_comb begin
    if (s1_flags_q.first_row) begin
      above = '0;
    end else if (s1_fwd_q) begin
      above = area_sum_q;
    end else begin
      above = rd_data;
    end
  end

  assign sum = s1_prefix_q + above;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = s1_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q    <= scan_col;
      s1_prefix_q <= scan_prefix;
      s1_flags_q  <= scan_flags;
      s1_fwd_q    <= fwd;
    end
    if (s1_valid_q && s1_adv) begin
      area_sum_q  <= sum;
      row_end_q   <= s1_flags_q.row_end;
      frame_end_q <= s1_flags_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign area_sum_o  = area_sum_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

endmodule

`default_nettype wire

// File: rtl/core/iis_checker.sv
`default_nettype none
`include "integral_image_stream_macros.svh"

module iis_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           pixel_ready_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_ready_i,
  input wire logic [iis_pkg::SumW-1:0]       area_sum_o,
  input wire logic                           row_end_o,
  input wire logic                           frame_end_o
);

  // A stalled result keeps its payload.
  `IIS_ASSERT(a_out_hold,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(area_sum_o) &&
      $stable(row_end_o) && $stable(frame_end_o),
    "output changed while stalled")

  // The last pixel of a frame is always the last pixel of a row.
  `IIS_ASSERT(a_frame_ends_row, out_valid_o && frame_end_o |-> row_end_o, "frame end without row end")

  // A cycle spent in reset leaves no result offered.
  `IIS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "output valid during reset")

  // Right after reset the line store is still being cleared, so no pixel is taken.
  `IIS_ASSERT(a_clear_after_reset, !$past(rst_ni) |-> !pixel_ready_o, "pixel taken during clear")

endmodule

bind integral_image_stream iis_checker u_iis_checker (.*);

`default_nettype wire

// File: verif/integral_image_stream_tb.sv
module integral_image_stream_tb;
  import iis_pkg::*;

  localparam int unsigned ClkHalf       = 4;
  localparam int unsigned MaxCols       = MaxWidthDefault;
  localparam int unsigned PixelBudget   = 530;
  localparam int unsigned TimeoutCycles = 400000;
  localparam int unsigned ReportLimit   = 10;
  // No register lives at this index, so a write here must change nothing.
  localparam logic [CfgIndexW-1:0] RegUnused = 8'hFF;

  typedef struct packed {
    logic [SumW-1:0] area_sum;
    logic            row_end;
    logic            frame_end;
  } pixel_sum_t;

  class integral_scoreboard;
    logic [ImgWidthW-1:0]  width_reg  = WidthReset;
    logic [ImgHeightW-1:0] height_reg = HeightReset;
    logic [SumW-1:0]       row_sum    = '0;
    bit   [SumW-1:0]       line_sums [MaxCols];
    int unsigned           col_pos    = 0;
    logic [ImgHeightW-1:0] row_pos    = '0;
    pixel_sum_t            pending_sums [$];
    int unsigned           mismatches   = 0;
    int unsigned           sums_checked = 0;
    int unsigned           row_ends     = 0;
    int unsigned           frame_ends   = 0;

    function void write_reg(logic [CfgIndexW-1:0] index, logic [CfgDataW-1:0] data);
      if (index == RegImageWidth) width_reg = data[ImgWidthW-1:0];
      else if (index == RegImageHeight) height_reg = data;
    endfunction

    function void take_pixel(logic [7:0] pixel);
      int unsigned w;
      int unsigned h;
      pixel_sum_t  s;
      w = (width_reg == 0) ? 1 : width_reg;
      if (w > MaxCols) w = MaxCols;
      h = (height_reg == 0) ? 1 : height_reg;
      row_sum = row_sum + pixel;
      // The first row of a frame ignores whatever the line store still holds.
      s.area_sum = row_sum + ((row_pos == 0) ? '0 : line_sums[col_pos]);
      line_sums[col_pos] = s.area_sum;
      s.row_end   = (col_pos + 1 >= w);
      s.frame_end = 1'b0;
      if (s.row_end) begin
        col_pos = 0;
        row_sum = '0;
        s.frame_end = (row_pos + 1 >= h);
        row_pos = s.frame_end ? '0 : row_pos + 1'b1;
      end else begin
        col_pos++;
      end
      pending_sums.push_back(s);
    endfunction

    function void check_sum(logic [SumW-1:0] area_sum, logic row_end, logic frame_end);
      pixel_sum_t want;
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected sum transfer: area_sum=%0d row_end=%b frame_end=%b",
                   area_sum, row_end, frame_end);
        return;
      end
      want = pending_sums.pop_front();
      sums_checked++;
      if (row_end === 1'b1) row_ends++;
      if (frame_end === 1'b1) frame_ends++;
      if (want.area_sum !== area_sum || want.row_end !== row_end ||
          want.frame_end !== frame_end) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("sum %0d mismatch: expected %0d/%b/%b, got %0d/%b/%b", sums_checked,
                   want.area_sum, want.row_end, want.frame_end, area_sum, row_end, frame_end);
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 pixel_valid_i = 1'b0;
  logic                 pixel_ready_o;
  logic [7:0]           pixel_i       = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [SumW-1:0]      area_sum_o;
  logic                 row_end_o;
  logic                 frame_end_o;

  integral_scoreboard board;
  int unsigned        pixels_sent = 0;
  int unsigned        cfg_writes  = 0;
  int unsigned        sink_hold   = 0;
  bit                 calm        = 1'b0;

  integral_image_stream i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_i       (pixel_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .area_sum_o    (area_sum_o),
    .row_end_o     (row_end_o),
    .frame_end_o   (frame_end_o)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Valid is left high after a transfer; it only drops when the sender idles.
  task automatic send_pixel(logic [7:0] pixel);
    if (!calm && $urandom_range(0, 99) < 20) begin
      pixel_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    pixel_valid_i <= 1'b1;
    pixel_i       <= pixel;
    do @(posedge clk_i); while (!pixel_ready_o);
    board.take_pixel(pixel);
    pixels_sent++;
  endtask

  task automatic program_reg(logic [CfgIndexW-1:0] index, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(index, data);
    cfg_writes++;
  endtask

  task automatic settle();
    pixel_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending_sums.size() != 0);
  endtask

  task automatic random_phase();
    logic [CfgDataW-1:0] data;
    int unsigned         count;
    settle();
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 9))
        0: data = 16'($urandom_range(MaxCols, 16'hFFFF));
        1: data = {4'($urandom_range(0, 15)), 12'h000};
        default: data = 16'($urandom_range(1, 12));
      endcase
      program_reg(RegImageWidth, data);
    end
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 9))
        0: data = 16'hFFFF;
        1: data = '0;
        default: data = 16'($urandom_range(1, 5));
      endcase
      program_reg(RegImageHeight, data);
    end
    if ($urandom_range(0, 9) == 0)
      program_reg(8'($urandom_range(2, 255)), 16'($urandom));
    cfg_valid_i <= 1'b0;
    count = $urandom_range(8, 48);
    repeat (count) send_pixel(pick_pixel());
  endtask

  // Sink side: random stalls, plus a long hold-off when the stimulus asks for one.
  initial begin
    int unsigned hold;
    hold = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i)
        board.check_sum(area_sum_o, row_end_o, frame_end_o);
      if (sink_hold != 0) begin
        hold      = sink_hold;
        sink_hold = 0;
      end
      if (hold != 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || $urandom_range(0, 99) >= 20;
      end
    end
  end

  initial begin
    logic [7:0] burst [$];
    board = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry, then pixel extremes.
    burst = {8'd255, 8'd0, 8'd255, 8'h80};
    foreach (burst[i]) send_pixel(burst[i]);

    // Shrinking the width mid-row: the column is already past the new last column,
    // so the next pixel closes the row.
    settle();
    program_reg(RegImageWidth, 16'd3);
    program_reg(RegImageHeight, 16'd2);
    cfg_valid_i <= 1'b0;
    burst = {8'd255, 8'd255, 8'd255, 8'd1, 8'd2, 8'd254, 8'd127};
    foreach (burst[i]) send_pixel(burst[i]);

    // Zero width and zero height both act as one.
    settle();
    program_reg(RegImageWidth, 16'hF000);
    program_reg(RegImageHeight, 16'h0000);
    cfg_valid_i <= 1'b0;
    burst = {8'h55, 8'hAA, 8'hFF};
    foreach (burst[i]) send_pixel(burst[i]);

    // Width beyond the line store saturates; height at its maximum.
    settle();
    program_reg(RegImageWidth, 16'hFFFF);
    program_reg(RegImageHeight, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    repeat (5) send_pixel(8'hFF);

    // A write to a missing register is dropped.
    settle();
    program_reg(RegUnused, 16'hFFFF);
    program_reg(RegImageWidth, 16'd2);
    cfg_valid_i <= 1'b0;
    burst = {8'd0, 8'd255, 8'd1, 8'h80};
    foreach (burst[i]) send_pixel(burst[i]);

    // Sink holds off while pixels keep coming, so the block backs up.
    settle();
    program_reg(RegImageWidth, 16'd5);
    program_reg(RegImageHeight, 16'd3);
    cfg_valid_i <= 1'b0;
    sink_hold = 120;
    repeat (40) send_pixel(pick_pixel());

    while (pixels_sent < PixelBudget) begin
      calm = (pixels_sent >= 250 && pixels_sent < 370);
      random_phase();
    end
    calm = 1'b0;

    pixel_valid_i <= 1'b0;
    while (board.pending_sums.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d pixels transferred across %0d register writes, widths 1 to %0d",
             pixels_sent, cfg_writes, MaxCols);
    $display("%0d sums checked, %0d row ends and %0d frame ends seen, %0d mismatches",
             board.sums_checked, board.row_ends, board.frame_ends, board.mismatches);
    if (board.mismatches == 0 && board.pending_sums.size() == 0) begin
      $display("integral_image_stream test passed");
    end else begin
      $display("integral_image_stream test failed");
    end
    $finish;
  end

  initial begin
    #(TimeoutCycles * 2 * ClkHalf);
    $display("timeout with %0d sums outstanding", board.pending_sums.size());
    $display("integral_image_stream test failed");
    $finish;
  end

endmodule
